// ===== src/tbrt_pkg.sv =====
// Shared types, constants and helpers for the timebase and reload timers.
package tbrt_pkg;

	// Counter and divider widths
	localparam int CNT_W = 16;
	localparam int DIV_W = 14;
	localparam int OUT_W = 16;

	// Divider orders of the fixed taps
	localparam logic [3:0] ORD_32768 = 4'd0;
	localparam logic [3:0] ORD_8192  = 4'd2;
	localparam logic [3:0] ORD_4096  = 4'd3;
	localparam logic [3:0] ORD_2048  = 4'd4;
	localparam logic [3:0] ORD_1024  = 4'd5;
	localparam logic [3:0] ORD_256   = 4'd7;
	localparam logic [3:0] ORD_TMB2  = 4'd8;
	localparam logic [3:0] ORD_TMB1  = 4'd12;
	localparam logic [3:0] ORD_4HZ   = 4'd13;
	localparam logic [3:0] ORD_2HZ   = 4'd14;

	// Item actions
	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_WR_A    = 3'd1,
		ACT_WR_B    = 3'd2,
		ACT_EN_A    = 3'd3,
		ACT_EN_B    = 3'd4,
		ACT_CLR_DIV = 3'd5
	} action_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_A_MAIN = 3'd0,
		CFG_A_AUX  = 3'd1,
		CFG_B_SRC  = 3'd2,
		CFG_TMB1   = 3'd3,
		CFG_TMB2   = 3'd4
	} cfg_idx_t;

	// Source select codes
	localparam logic [2:0] SRC_32768 = 3'd2;
	localparam logic [2:0] SRC_8192  = 3'd3;
	localparam logic [2:0] SRC_4096  = 3'd4;
	localparam logic [2:0] SRC_AUX   = 3'd5;
	localparam logic [2:0] AUX_2048  = 3'd0;
	localparam logic [2:0] AUX_1024  = 3'd1;
	localparam logic [2:0] AUX_256   = 3'd2;
	localparam logic [2:0] AUX_TMB1  = 3'd3;
	localparam logic [2:0] AUX_4HZ   = 3'd4;
	localparam logic [2:0] AUX_2HZ   = 3'd5;
	localparam logic [2:0] SRC_NONE  = 3'd6;

	// A divided tick selection: on = 0 means the source is off
	typedef struct packed {
		logic       on;
		logic [3:0] n;
	} order_t;

	// One result transaction
	typedef struct packed {
		logic [OUT_W-1:0] count_a;
		logic [OUT_W-1:0] count_b;
		logic             irq_timer_a;
		logic             irq_timer_b;
		logic             irq_4096;
		logic             irq_2048;
		logic             irq_1024;
		logic             irq_tmb2;
		logic             irq_tmb1;
		logic             irq_4hz;
	} result_t;

	// Divided tick fires when the low n divider bits are all zero
	function automatic logic fires(logic [DIV_W-1:0] div, order_t ord);
		logic hit;
		hit = ord.on;
		for (int i = 0; i < DIV_W; i++) begin
			if ((i < int'(ord.n)) && div[i]) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

// ===== src/timebase_and_reload_timers.sv =====
// Timebase divider, two reload timers and their interrupt pulses.
// Each input transaction is one 32768 Hz tick or one register access, and
// it yields exactly one result transaction carrying both counts and the
// interrupt pulses raised by that item. The block takes one item per clock
// cycle while the output queue has room: an item waits in the input register,
// where the divider, counters and enables are updated in a single pass, and
// its result is then written into a two-entry output queue whose head drives
// the ports; when the queue is full and not read, the input register stalls.
// Input keeps flowing while one result waits.
// Source and rate registers are written through the configuration channel,
// which is always ready and should only be used while no item is in flight.
module timebase_and_reload_timers
	import tbrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [15:0]       value,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  count_a,
	output logic [OUT_W-1:0]  count_b,
	output logic              irq_timer_a,
	output logic              irq_timer_b,
	output logic              irq_4096,
	output logic              irq_2048,
	output logic              irq_1024,
	output logic              irq_tmb2,
	output logic              irq_tmb1,
	output logic              irq_4hz,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [2:0]        cfg_data
);

	// configuration registers
	logic [2:0] a_main_q, a_aux_q, b_src_q;
	logic [1:0] tmb1_rate_q, tmb2_rate_q;

	// timer state
	logic [DIV_W-1:0] divider_q, divider_d;
	logic [CNT_W-1:0] counter_a_q, counter_a_d, preload_a_q, preload_a_d;
	logic [CNT_W-1:0] counter_b_q, counter_b_d, preload_b_q, preload_b_d;
	logic             enable_a_q, enable_a_d, enable_b_q, enable_b_d;

	// input register
	logic              valid_s1;
	logic [2:0]        action_s1;
	logic [15:0]       value_s1;

	// output queue
	result_t q_mem_q [2];
	logic    wr_ptr_q, rd_ptr_q;
	logic [1:0] q_cnt_q;

	logic    process, pop, q_space;
	result_t res;
	order_t  ord_a, ord_b, ord_tmb1, ord_tmb2;
	logic [DIV_W-1:0] div_inc;
	logic [CNT_W-1:0] inc_a, inc_b;
	logic    fire_a, fire_b, wrap_a, wrap_b;

	// handshake
	assign pop       = out_valid && out_ready;
	assign out_valid = (q_cnt_q != 2'd0);
	assign q_space   = (q_cnt_q != 2'd2) || pop;
	assign process   = valid_s1 && q_space;
	assign in_ready  = !valid_s1 || process;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_main_q    <= SRC_NONE;
			a_aux_q     <= SRC_NONE;
			b_src_q     <= SRC_NONE;
			tmb1_rate_q <= 2'd0;
			tmb2_rate_q <= 2'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_A_MAIN: a_main_q    <= cfg_data;
				CFG_A_AUX:  a_aux_q     <= cfg_data;
				CFG_B_SRC:  b_src_q     <= cfg_data;
				CFG_TMB1:   tmb1_rate_q <= cfg_data[1:0];
				CFG_TMB2:   tmb2_rate_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// selectable timebase orders
	always_comb begin
		ord_tmb1 = '{on: 1'b1, n: ORD_TMB1 - {2'b00, tmb1_rate_q}};
		ord_tmb2 = '{on: 1'b1, n: ORD_TMB2 - {2'b00, tmb2_rate_q}};
	end

	// timer A source decode; main taps only valid with aux parked at none
	always_comb begin
		ord_a = '{on: 1'b0, n: 4'd0};
		if (a_main_q == SRC_AUX) begin
			unique case (a_aux_q)
				AUX_2048: ord_a = '{on: 1'b1, n: ORD_2048};
				AUX_1024: ord_a = '{on: 1'b1, n: ORD_1024};
				AUX_256:  ord_a = '{on: 1'b1, n: ORD_256};
				AUX_TMB1: ord_a = ord_tmb1;
				AUX_4HZ:  ord_a = '{on: 1'b1, n: ORD_4HZ};
				AUX_2HZ:  ord_a = '{on: 1'b1, n: ORD_2HZ};
				default:  ord_a = '{on: 1'b0, n: 4'd0};
			endcase
		end else if (a_aux_q == SRC_NONE) begin
			unique case (a_main_q)
				SRC_32768: ord_a = '{on: 1'b1, n: ORD_32768};
				SRC_8192:  ord_a = '{on: 1'b1, n: ORD_8192};
				SRC_4096:  ord_a = '{on: 1'b1, n: ORD_4096};
				default:   ord_a = '{on: 1'b0, n: 4'd0};
			endcase
		end
	end

	// timer B source decode
	always_comb begin
		unique case (b_src_q)
			SRC_32768: ord_b = '{on: 1'b1, n: ORD_32768};
			SRC_8192:  ord_b = '{on: 1'b1, n: ORD_8192};
			SRC_4096:  ord_b = '{on: 1'b1, n: ORD_4096};
			default:   ord_b = '{on: 1'b0, n: 4'd0};
		endcase
	end

	// tick arithmetic against the incremented divider
	always_comb begin
		div_inc = divider_q + 1'b1;
		fire_a  = enable_a_q && fires(div_inc, ord_a);
		fire_b  = enable_b_q && fires(div_inc, ord_b);
		inc_a   = counter_a_q + 1'b1;
		inc_b   = counter_b_q + 1'b1;
		wrap_a  = fire_a && (inc_a == '0);
		wrap_b  = fire_b && (inc_b == '0);
	end

	// action decode: next state and result
	always_comb begin
		divider_d   = divider_q;
		counter_a_d = counter_a_q;
		counter_b_d = counter_b_q;
		preload_a_d = preload_a_q;
		preload_b_d = preload_b_q;
		enable_a_d  = enable_a_q;
		enable_b_d  = enable_b_q;
		res         = '0;
		unique case (action_s1)
			ACT_TICK: begin
				divider_d = div_inc;
				if (fire_a) begin
					counter_a_d = wrap_a ? preload_a_q : inc_a;
				end
				if (fire_b) begin
					counter_b_d = wrap_b ? preload_b_q : inc_b;
				end
				res.irq_timer_a = wrap_a;
				res.irq_timer_b = wrap_b;
				res.irq_4096    = fires(div_inc, '{on: 1'b1, n: ORD_4096});
				res.irq_2048    = fires(div_inc, '{on: 1'b1, n: ORD_2048});
				res.irq_1024    = fires(div_inc, '{on: 1'b1, n: ORD_1024});
				res.irq_tmb2    = fires(div_inc, ord_tmb2);
				res.irq_tmb1    = fires(div_inc, ord_tmb1);
				res.irq_4hz     = fires(div_inc, '{on: 1'b1, n: ORD_4HZ});
			end
			ACT_WR_A: begin
				preload_a_d = CNT_W'(value_s1);
				counter_a_d = CNT_W'(value_s1);
			end
			ACT_WR_B: begin
				preload_b_d = CNT_W'(value_s1);
				counter_b_d = CNT_W'(value_s1);
			end
			ACT_EN_A:    enable_a_d = value_s1[0];
			ACT_EN_B:    enable_b_d = value_s1[0];
			ACT_CLR_DIV: divider_d  = '0;
			default: ;
		endcase
		res.count_a = OUT_W'(counter_a_d);
		res.count_b = OUT_W'(counter_b_d);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			value_s1  <= value;
		end
	end

	// timer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q   <= '0;
			counter_a_q <= '0;
			counter_b_q <= '0;
			preload_a_q <= '0;
			preload_b_q <= '0;
			enable_a_q  <= 1'b0;
			enable_b_q  <= 1'b0;
		end else if (process) begin
			divider_q   <= divider_d;
			counter_a_q <= counter_a_d;
			counter_b_q <= counter_b_d;
			preload_a_q <= preload_a_d;
			preload_b_q <= preload_b_d;
			enable_a_q  <= enable_a_d;
			enable_b_q  <= enable_b_d;
		end
	end

	// output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			q_cnt_q  <= 2'd0;
		end else begin
			if (process) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (process && !pop) begin
				q_cnt_q <= q_cnt_q + 2'd1;
			end else if (!process && pop) begin
				q_cnt_q <= q_cnt_q - 2'd1;
			end
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (process) begin
			q_mem_q[wr_ptr_q] <= res;
		end
	end

	// result ports from queue head
	assign count_a     = q_mem_q[rd_ptr_q].count_a;
	assign count_b     = q_mem_q[rd_ptr_q].count_b;
	assign irq_timer_a = q_mem_q[rd_ptr_q].irq_timer_a;
	assign irq_timer_b = q_mem_q[rd_ptr_q].irq_timer_b;
	assign irq_4096    = q_mem_q[rd_ptr_q].irq_4096;
	assign irq_2048    = q_mem_q[rd_ptr_q].irq_2048;
	assign irq_1024    = q_mem_q[rd_ptr_q].irq_1024;
	assign irq_tmb2    = q_mem_q[rd_ptr_q].irq_tmb2;
	assign irq_tmb1    = q_mem_q[rd_ptr_q].irq_tmb1;
	assign irq_4hz     = q_mem_q[rd_ptr_q].irq_4hz;

endmodule

// ===== src/tbrt_checker.sv =====
// Port-level assertions for the timebase and reload timers, with bind.
module tbrt_checker
	import tbrt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] count_a,
	input logic [OUT_W-1:0] count_b,
	input logic             irq_4096,
	input logic             irq_2048,
	input logic             irq_1024,
	input logic             irq_tmb2,
	input logic             irq_tmb1,
	input logic             irq_4hz
);

	// a stalled result transaction holds its counts
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count_a) && $stable(count_b))
		else $error("result changed while stalled");

	// 4 Hz lies on a boundary of every faster fixed tap
	a_4hz_nest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq_4hz |-> irq_1024 && irq_2048 && irq_4096)
		else $error("4 Hz pulse without faster timebase pulses");

	// timebase 1 is never faster than timebase 2
	a_tmb_nest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq_tmb1 |-> irq_tmb2)
		else $error("timebase 1 pulse without timebase 2 pulse");

	// timebase 2 is at most 1024 Hz
	a_tmb2_nest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq_tmb2 |-> irq_1024 && irq_2048)
		else $error("timebase 2 pulse without 1024 Hz pulse");

endmodule

bind timebase_and_reload_timers tbrt_checker u_tbrt_checker (.*);
